### rtl/core/cfd_pkg.sv
// shared types and constants for the command fifo with automatic dequeue
// no dependencies
package cfd_pkg;

	localparam int DEPTH  = 32;
	localparam int ADDR_W = $clog2(DEPTH);
	localparam int FILL_W = 6;
	localparam int DATA_W = 32;
	localparam int CNT_W  = 6;

	localparam logic [FILL_W-1:0] CAP_RESET = FILL_W'(DEPTH);

	typedef enum logic [2:0] {
		CMD_ENQ   = 3'd0,
		CMD_DEQ   = 3'd1,
		CMD_BATCH = 3'd2,
		CMD_FLUSH = 3'd3,
		CMD_IND   = 3'd4
	} cmd_t;

	typedef enum logic [2:0] {
		KIND_DATA    = 3'd0,
		KIND_BCOUNT  = 3'd1,
		KIND_BEMPTY  = 3'd2,
		KIND_NONE    = 3'd3,
		KIND_NOTFULL = 3'd4,
		KIND_FULL    = 3'd5,
		KIND_EMPTY   = 3'd6
	} kind_t;

	localparam logic [1:0] REG_CAPACITY   = 2'd0;
	localparam logic [1:0] REG_AUTO_FIRST = 2'd1;
	localparam logic [1:0] REG_KEEP_POP   = 2'd2;
	localparam logic [1:0] REG_AUTO_FULL  = 2'd3;

	typedef struct packed {
		logic [FILL_W-1:0] capacity;
		logic              auto_pop_first;
		logic              keep_pending_pop;
		logic              auto_pop_full;
	} cfg_t;

	typedef struct packed {
		logic              we;
		logic [ADDR_W-1:0] waddr;
		logic [DATA_W-1:0] wdata;
		logic              re;
		logic [ADDR_W-1:0] raddr;
	} ram_req_t;

endpackage

### rtl/core/cfd_ram.sv
// word store of the queue: one write and one registered read port
// depends on cfd_pkg
module cfd_ram (
	input  logic                       clk,
	input  cfd_pkg::ram_req_t          req,
	output logic [cfd_pkg::DATA_W-1:0] rdata
);

	logic [cfd_pkg::DATA_W-1:0] mem [cfd_pkg::DEPTH];
	logic [cfd_pkg::DATA_W-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (req.we) begin
			mem[req.waddr] <= req.wdata;
		end
		// read data holds until the next read
		if (req.re) begin
			rdata_q <= mem[req.raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

### rtl/core/cfd_regs.sv
// configuration registers behind the apb-style port
// depends on cfd_pkg
module cfd_regs (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               psel,
	input  logic               penable,
	input  logic               pwrite,
	input  logic [3:0]         paddr,
	input  logic [31:0]        pwdata,
	output logic [31:0]        prdata,
	output cfd_pkg::cfg_t      cfg
);

	cfd_pkg::cfg_t cfg_q;
	logic          wr;

	assign wr = psel && penable && pwrite;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.capacity         <= cfd_pkg::CAP_RESET;
			cfg_q.auto_pop_first   <= 1'b0;
			cfg_q.keep_pending_pop <= 1'b0;
			cfg_q.auto_pop_full    <= 1'b0;
		end else if (wr) begin
			case (paddr[3:2])
				cfd_pkg::REG_CAPACITY:   cfg_q.capacity <= pwdata[cfd_pkg::FILL_W-1:0];
				cfd_pkg::REG_AUTO_FIRST: cfg_q.auto_pop_first <= pwdata[0];
				cfd_pkg::REG_KEEP_POP:   cfg_q.keep_pending_pop <= pwdata[0];
				cfd_pkg::REG_AUTO_FULL:  cfg_q.auto_pop_full <= pwdata[0];
				default: ;
			endcase
		end
	end

	always_comb begin
		case (paddr[3:2])
			cfd_pkg::REG_CAPACITY:   prdata = 32'(cfg_q.capacity);
			cfd_pkg::REG_AUTO_FIRST: prdata = 32'(cfg_q.auto_pop_first);
			cfd_pkg::REG_KEEP_POP:   prdata = 32'(cfg_q.keep_pending_pop);
			cfd_pkg::REG_AUTO_FULL:  prdata = 32'(cfg_q.auto_pop_full);
			default:                 prdata = 32'd0;
		endcase
	end

	assign cfg = cfg_q;

endmodule

### rtl/core/cfd_ctrl.sv
// command decode, queue pointers, result sequencer and output register
// depends on cfd_pkg; drives the store in cfd_ram
module cfd_ctrl (
	input  logic                       clk,
	input  logic                       arst_n,
	input  cfd_pkg::cfg_t              cfg,
	input  logic                       in_valid,
	output logic                       in_ready,
	input  logic [2:0]                 cmd,
	input  logic [31:0]                word_in,
	input  logic [5:0]                 batch_count,
	input  logic                       trigger_flag,
	output logic                       out_valid,
	input  logic                       out_ready,
	output logic [2:0]                 kind,
	output logic [31:0]                word_out,
	output logic [5:0]                 count_out,
	output logic                       last,
	output cfd_pkg::ram_req_t          ram_req,
	input  logic [cfd_pkg::DATA_W-1:0] ram_rdata
);

	localparam int AW = cfd_pkg::ADDR_W;
	localparam int FW = cfd_pkg::FILL_W;
	localparam int CW = cfd_pkg::CNT_W;

	// queue state
	logic [AW-1:0] head_q;
	logic [FW-1:0] fill_q;
	logic          pop_pend_q, first_pend_q, first_ind_q;

	// result plan of the current command: leading notice, pops, trailing count
	logic                 pre_v_q;
	cfd_pkg::kind_t       pre_kind_q;
	logic [FW-1:0]        pops_q;
	logic                 rd_q;
	logic                 post_v_q;
	logic [CW-1:0]        post_cnt_q;

	// output register
	logic                 out_v_q;
	cfd_pkg::kind_t       out_kind_q;
	logic [31:0]          out_word_q;
	logic [CW-1:0]        out_cnt_q;
	logic                 out_last_q;

	logic          busy, acc, out_free, ld_pre, ld_data, ld_post, issue;
	logic [FW-1:0] cap, fill1, fill2, take;
	logic          enq_ok, enq_full, p1, p2, p2_cond, first_hit;

	logic                 nx_pre_v;
	cfd_pkg::kind_t       nx_pre_kind;
	logic [FW-1:0]        nx_pops;
	logic                 nx_post_v;
	logic [CW-1:0]        nx_post_cnt;
	logic [FW-1:0]        nx_fill;
	logic                 nx_pop_pend, nx_first_pend, nx_first_ind;

	assign cap = (cfg.capacity > FW'(cfd_pkg::DEPTH)) ? FW'(cfd_pkg::DEPTH) : cfg.capacity;

	assign busy     = pre_v_q || (pops_q != '0) || rd_q || post_v_q;
	assign in_ready = !busy;
	assign acc      = in_valid && in_ready;

	assign out_free = !out_v_q || out_ready;
	assign ld_pre   = out_free && pre_v_q;
	assign ld_data  = out_free && !pre_v_q && rd_q;
	assign ld_post  = out_free && !pre_v_q && !rd_q && (pops_q == '0) && post_v_q;
	// a new read may go out as the previous word moves to the output
	assign issue    = (pops_q != '0) && (!rd_q || ld_data);

	// enqueue arithmetic
	assign enq_ok    = fill_q < cap;
	assign fill1     = fill_q + FW'(1);
	assign enq_full  = fill1 >= cap;
	assign p1        = cfg.auto_pop_full && enq_full;
	assign fill2     = fill1 - FW'(p1);
	assign first_hit = first_pend_q && cfg.auto_pop_first;
	assign p2_cond   = first_hit || pop_pend_q;
	assign p2        = p2_cond && (fill2 != '0);
	assign take      = (batch_count < fill_q) ? batch_count : fill_q;

	always_comb begin
		nx_pre_v      = 1'b0;
		nx_pre_kind   = cfd_pkg::KIND_NOTFULL;
		nx_pops       = '0;
		nx_post_v     = 1'b0;
		nx_post_cnt   = '0;
		nx_fill       = fill_q;
		nx_pop_pend   = pop_pend_q;
		nx_first_pend = first_pend_q;
		nx_first_ind  = first_ind_q;
		case (cmd)
			cfd_pkg::CMD_ENQ: begin
				if (enq_ok) begin
					nx_fill     = fill1;
					nx_pre_v    = 1'b1;
					nx_pre_kind = enq_full ? cfd_pkg::KIND_FULL : cfd_pkg::KIND_NOTFULL;
					nx_pops     = FW'(p1) + FW'(p2);
					if (p2) begin
						if (first_hit) begin
							nx_first_pend = 1'b0;
						end else begin
							nx_pop_pend = 1'b0;
						end
					end
				end
			end
			cfd_pkg::CMD_DEQ: begin
				if (fill_q != '0) begin
					nx_pops = FW'(1);
				end else begin
					nx_pre_v    = 1'b1;
					nx_pre_kind = cfd_pkg::KIND_EMPTY;
					if (cfg.keep_pending_pop) begin
						nx_pop_pend = 1'b1;
					end
				end
			end
			cfd_pkg::CMD_BATCH: begin
				if (fill_q == '0) begin
					nx_pre_v    = 1'b1;
					nx_pre_kind = cfd_pkg::KIND_BEMPTY;
				end else if (batch_count == '0) begin
					nx_pre_v    = 1'b1;
					nx_pre_kind = cfd_pkg::KIND_NONE;
				end else begin
					nx_pops     = take;
					nx_post_v   = 1'b1;
					nx_post_cnt = CW'(take);
				end
			end
			cfd_pkg::CMD_FLUSH: begin
				nx_fill = '0;
			end
			cfd_pkg::CMD_IND: begin
				if (first_ind_q) begin
					nx_first_ind = 1'b0;
					nx_pre_v     = 1'b1;
				end else if (trigger_flag) begin
					nx_pre_v = 1'b1;
				end
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			head_q       <= '0;
			fill_q       <= '0;
			pop_pend_q   <= 1'b0;
			first_pend_q <= 1'b1;
			first_ind_q  <= 1'b1;
			pre_v_q      <= 1'b0;
			pops_q       <= '0;
			rd_q         <= 1'b0;
			post_v_q     <= 1'b0;
			out_v_q      <= 1'b0;
		end else begin
			if (acc) begin
				pre_v_q      <= nx_pre_v;
				pops_q       <= nx_pops;
				post_v_q     <= nx_post_v;
				fill_q       <= nx_fill;
				pop_pend_q   <= nx_pop_pend;
				first_pend_q <= nx_first_pend;
				first_ind_q  <= nx_first_ind;
			end else begin
				if (ld_pre) begin
					pre_v_q <= 1'b0;
				end
				if (issue) begin
					pops_q <= pops_q - FW'(1);
					head_q <= head_q + AW'(1);
					fill_q <= fill_q - FW'(1);
				end
				if (ld_post) begin
					post_v_q <= 1'b0;
				end
			end
			if (issue) begin
				rd_q <= 1'b1;
			end else if (ld_data) begin
				rd_q <= 1'b0;
			end
			if (ld_pre || ld_data || ld_post) begin
				out_v_q <= 1'b1;
			end else if (out_ready) begin
				out_v_q <= 1'b0;
			end
		end
	end

	// plan payload and output payload
	always_ff @(posedge clk) begin
		if (acc) begin
			pre_kind_q <= nx_pre_kind;
			post_cnt_q <= nx_post_cnt;
		end
		if (ld_pre) begin
			out_kind_q <= pre_kind_q;
			out_word_q <= '0;
			out_cnt_q  <= '0;
			out_last_q <= (pops_q == '0) && !rd_q && !post_v_q;
		end else if (ld_data) begin
			out_kind_q <= cfd_pkg::KIND_DATA;
			out_word_q <= 32'(ram_rdata);
			out_cnt_q  <= '0;
			out_last_q <= (pops_q == '0) && !post_v_q;
		end else if (ld_post) begin
			out_kind_q <= cfd_pkg::KIND_BCOUNT;
			out_word_q <= '0;
			out_cnt_q  <= post_cnt_q;
			out_last_q <= 1'b1;
		end
	end

	assign ram_req.we    = acc && (cmd == cfd_pkg::CMD_ENQ) && enq_ok;
	assign ram_req.waddr = head_q + fill_q[AW-1:0];
	assign ram_req.wdata = word_in[cfd_pkg::DATA_W-1:0];
	assign ram_req.re    = issue;
	assign ram_req.raddr = head_q;

	assign out_valid = out_v_q;
	assign kind      = out_kind_q;
	assign word_out  = out_word_q;
	assign count_out = out_cnt_q;
	assign last      = out_last_q;

endmodule

### rtl/core/command_fifo_auto_dequeue.sv
// top level of the command fifo with automatic dequeue
// depends on cfd_pkg, cfd_regs, cfd_ctrl and cfd_ram
//
// usage: commands arrive on the in channel (cmd, word_in, batch_count,
// trigger_flag) and results leave on the out channel (kind, word_out,
// count_out, last), both valid/ready; last marks the final result of a
// command. configuration sits behind the apb-style port and is to be
// written only while the block is idle; the block does not enforce this.
// one command is worked on at a time. its result plan is registered at the
// input transfer and results leave through the output register; each popped
// word costs one read of the store, whose data is registered, and with the
// receiver ready reads overlap with output transfers. a batch of n words
// gives n + 1 results. a command with no result (flush, a dropped enqueue,
// a later indicate with no trigger, unused codes) keeps in_ready high.
// the next command is taken once the last result of the previous one sits
// in the output register. if the receiver stalls, the output register
// holds its result and the sequencer waits.
// reset clears pointers, flags and configuration at once; the store is not
// cleared and no clearing pass is needed, as only queued entries are read.
module command_fifo_auto_dequeue (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [3:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [2:0]  cmd,
	input  logic [31:0] word_in,
	input  logic [5:0]  batch_count,
	input  logic        trigger_flag,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [2:0]  kind,
	output logic [31:0] word_out,
	output logic [5:0]  count_out,
	output logic        last
);

	cfd_pkg::cfg_t              cfg;
	cfd_pkg::ram_req_t          ram_req;
	logic [cfd_pkg::DATA_W-1:0] ram_rdata;

	assign pready = 1'b1;

	cfd_regs u_regs (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.cfg     (cfg)
	);

	cfd_ctrl u_ctrl (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg          (cfg),
		.in_valid     (in_valid),
		.in_ready     (in_ready),
		.cmd          (cmd),
		.word_in      (word_in),
		.batch_count  (batch_count),
		.trigger_flag (trigger_flag),
		.out_valid    (out_valid),
		.out_ready    (out_ready),
		.kind         (kind),
		.word_out     (word_out),
		.count_out    (count_out),
		.last         (last),
		.ram_req      (ram_req),
		.ram_rdata    (ram_rdata)
	);

	cfd_ram u_ram (
		.clk   (clk),
		.req   (ram_req),
		.rdata (ram_rdata)
	);

endmodule

### verif/cfd_result_checker.sv
// result checker for command_fifo_auto_dequeue: mirrors the queue, predicts every result
// of each accepted command and compares the out channel against it
// depends on cfd_pkg
module cfd_result_checker
	import cfd_pkg::*;
(
	input  logic              clk,
	input  logic              arst_n,
	input  logic              psel,
	input  logic              penable,
	input  logic              pwrite,
	input  logic              pready,
	input  logic [3:0]        paddr,
	input  logic [31:0]       pwdata,
	input  logic              in_valid,
	input  logic              in_ready,
	input  logic [2:0]        cmd,
	input  logic [DATA_W-1:0] word_in,
	input  logic [CNT_W-1:0]  batch_count,
	input  logic              trigger_flag,
	input  logic              out_valid,
	input  logic              out_ready,
	input  logic [2:0]        kind,
	input  logic [DATA_W-1:0] word_out,
	input  logic [CNT_W-1:0]  count_out,
	input  logic              last,
	output int                fail_count,
	output int                outstanding
);
	timeunit 1ns;
	timeprecision 1ps;

	typedef struct packed {
		kind_t             kind;
		logic [DATA_W-1:0] word;
		logic [CNT_W-1:0]  count;
		logic              last;
	} result_t;

	result_t pending_results[$];
	int      failures = 0;

	// mirrored queue and flags
	logic [DATA_W-1:0] mirror_mem [DEPTH];
	logic [ADDR_W-1:0] rd_ptr;
	int unsigned       level;
	logic              pop_pending;
	logic              first_pending;
	logic              first_indicate;

	// mirrored registers
	logic [FILL_W-1:0] cfg_cap;
	logic              cfg_auto_first;
	logic              cfg_keep_pop;
	logic              cfg_auto_full;

	function void post(kind_t k, logic [DATA_W-1:0] w, logic [CNT_W-1:0] n);
		result_t r;
		r.kind  = k;
		r.word  = w;
		r.count = n;
		r.last  = 1'b0;
		pending_results.push_back(r);
	endfunction

	function void pop_oldest();
		post(KIND_DATA, mirror_mem[rd_ptr], '0);
		rd_ptr++;
		level--;
	endfunction

	function void apply_command(logic [2:0] c, logic [DATA_W-1:0] w, logic [CNT_W-1:0] want,
		logic trig);
		int unsigned       cap_eff;
		int unsigned       take;
		int                before_n;
		result_t           r;
		logic [ADDR_W-1:0] wr_idx;
		before_n = pending_results.size();
		cap_eff  = (cfg_cap > DEPTH) ? DEPTH : cfg_cap;
		case (c)
			CMD_ENQ: begin
				if (level < cap_eff) begin
					wr_idx = rd_ptr + ADDR_W'(level);
					mirror_mem[wr_idx] = w;
					level++;
					if (level < cap_eff) begin
						post(KIND_NOTFULL, '0, '0);
					end else begin
						post(KIND_FULL, '0, '0);
						if (cfg_auto_full && level > 0)
							pop_oldest();
					end
					// first-pop takes priority over a remembered dequeue
					if (((first_pending && cfg_auto_first) || pop_pending) && level > 0) begin
						pop_oldest();
						if (first_pending && cfg_auto_first)
							first_pending = 1'b0;
						else
							pop_pending = 1'b0;
					end
				end
			end
			CMD_DEQ: begin
				if (level > 0) begin
					pop_oldest();
				end else begin
					if (cfg_keep_pop)
						pop_pending = 1'b1;
					post(KIND_EMPTY, '0, '0);
				end
			end
			CMD_BATCH: begin
				if (level == 0) begin
					post(KIND_BEMPTY, '0, '0);
				end else if (want == 0) begin
					post(KIND_NONE, '0, '0);
				end else begin
					take = (want < level) ? want : level;
					for (int i = 0; i < take; i++)
						pop_oldest();
					post(KIND_BCOUNT, '0, CNT_W'(take));
				end
			end
			CMD_FLUSH: level = 0;
			CMD_IND: begin
				if (first_indicate) begin
					first_indicate = 1'b0;
					post(KIND_NOTFULL, '0, '0);
				end else if (trig) begin
					post(KIND_NOTFULL, '0, '0);
				end
			end
			default: ;
		endcase
		if (pending_results.size() > before_n) begin
			r = pending_results.pop_back();
			r.last = 1'b1;
			pending_results.push_back(r);
		end
	endfunction

	function void take_reg_write();
		case (paddr[3:2])
			REG_CAPACITY:   cfg_cap        = pwdata[FILL_W-1:0];
			REG_AUTO_FIRST: cfg_auto_first = pwdata[0];
			REG_KEEP_POP:   cfg_keep_pop   = pwdata[0];
			REG_AUTO_FULL:  cfg_auto_full  = pwdata[0];
			default: ;
		endcase
	endfunction

	function void compare_result();
		result_t want_r;
		if (pending_results.size() == 0) begin
			failures++;
			if (failures <= 10)
				$display("unexpected result: kind %0d word %h count %0d last %b",
					kind, word_out, count_out, last);
		end else begin
			want_r = pending_results.pop_front();
			if (want_r.kind !== kind || want_r.word !== word_out ||
			    want_r.count !== count_out || want_r.last !== last) begin
				failures++;
				if (failures <= 10)
					$display("mismatch: expected %0d %h %0d %b, got %0d %h %0d %b",
						want_r.kind, want_r.word, want_r.count, want_r.last,
						kind, word_out, count_out, last);
			end
		end
	endfunction

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rd_ptr         = '0;
			level          = 0;
			pop_pending    = 1'b0;
			first_pending  = 1'b1;
			first_indicate = 1'b1;
			cfg_cap        = CAP_RESET;
			cfg_auto_first = 1'b0;
			cfg_keep_pop   = 1'b0;
			cfg_auto_full  = 1'b0;
			pending_results.delete();
			outstanding <= 0;
			fail_count  <= failures;
		end else begin
			// results first: nothing emitted at an edge can belong to a command taken there
			if (out_valid && out_ready)
				compare_result();
			if (psel && penable && pwrite && pready)
				take_reg_write();
			if (in_valid && in_ready)
				apply_command(cmd, word_in, batch_count, trigger_flag);
			outstanding <= pending_results.size();
			fail_count  <= failures;
		end
	end

endmodule

### verif/tb_top.sv
// top of the command_fifo_auto_dequeue testbench: clock, reset, register writes, command
// stimulus with idle and stall phases, and the verdict
// depends on cfd_pkg, command_fifo_auto_dequeue and cfd_result_checker
module tb_top;
	import cfd_pkg::*;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int         RUN_LIMIT       = 300000;
	localparam logic [2:0] FIRST_SPARE_CMD = 3'd5;
	localparam logic [2:0] LAST_SPARE_CMD  = 3'd7;

	logic        clk;
	logic        arst_n;
	logic        psel;
	logic        penable;
	logic        pwrite;
	logic [3:0]  paddr;
	logic [31:0] pwdata;
	logic [31:0] prdata;
	logic        pready;
	logic        in_valid;
	logic        in_ready;
	logic [2:0]  cmd;
	logic [31:0] word_in;
	logic [5:0]  batch_count;
	logic        trigger_flag;
	logic        out_valid;
	logic        out_ready = 1'b0;
	logic [2:0]  kind;
	logic [31:0] word_out;
	logic [5:0]  count_out;
	logic        last;

	int fail_count;
	int outstanding;
	int idle_pct  = 0;
	int stall_pct = 0;
	int cycles    = 0;

	command_fifo_auto_dequeue DUT (.*);

	cfd_result_checker u_checker (.*);

	initial begin
		clk = 1'b0;
		forever #10 clk = ~clk;
	end

	initial begin
		while (cycles < RUN_LIMIT) begin
			@(posedge clk);
			cycles++;
		end
		$display("[FAIL] regression broken");
		$finish;
	end

	// receiver back-pressure
	always @(posedge clk)
		out_ready <= ($urandom_range(99) >= stall_pct);

	task automatic write_reg(input logic [1:0] idx, input logic [31:0] val);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= {idx, 2'b00};
		pwdata  <= val;
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		psel    <= 1'b0;
		penable <= 1'b0;
		@(posedge clk);
	endtask

	// let every predicted result drain, then allow for commands that give none
	task automatic settle();
		in_valid <= 1'b0;
		@(posedge clk);
		while (outstanding != 0)
			@(posedge clk);
		repeat (12) @(posedge clk);
	endtask

	task automatic retune(input logic [5:0] cap, input logic first, input logic keep,
		input logic full);
		settle();
		write_reg(REG_CAPACITY, 32'(cap));
		write_reg(REG_AUTO_FIRST, 32'(first));
		write_reg(REG_KEEP_POP, 32'(keep));
		write_reg(REG_AUTO_FULL, 32'(full));
	endtask

	task automatic push_cmd(input logic [2:0] c, input logic [31:0] w, input logic [5:0] n,
		input logic t);
		if ($urandom_range(99) < idle_pct) begin
			in_valid <= 1'b0;
			do @(posedge clk); while ($urandom_range(99) < idle_pct);
		end
		in_valid     <= 1'b1;
		cmd          <= c;
		word_in      <= w;
		batch_count  <= n;
		trigger_flag <= t;
		do @(posedge clk); while (!in_ready);
	endtask

	task automatic random_traffic(input int count, input int enq_pct);
		logic [2:0]  c;
		logic [31:0] w;
		logic [5:0]  n;
		int          pick;
		for (int i = 0; i < count; i++) begin
			pick = $urandom_range(99);
			if (pick < enq_pct) begin
				c = CMD_ENQ;
			end else begin
				pick = $urandom_range(99);
				if (pick < 30)
					c = CMD_DEQ;
				else if (pick < 62)
					c = CMD_BATCH;
				else if (pick < 72)
					c = CMD_FLUSH;
				else if (pick < 90)
					c = CMD_IND;
				else
					c = 3'($urandom_range(FIRST_SPARE_CMD, LAST_SPARE_CMD));
			end
			pick = $urandom_range(99);
			if (pick < 10)
				w = '0;
			else if (pick < 20)
				w = '1;
			else
				w = $urandom;
			pick = $urandom_range(99);
			if (pick < 10)
				n = '0;
			else if (pick < 20)
				n = '1;
			else if (pick < 35)
				n = 6'($urandom_range(0, 63));
			else
				n = 6'($urandom_range(1, 8));
			push_cmd(c, w, n, 1'($urandom_range(1)));
		end
	endtask

	initial begin
		arst_n       = 1'b0;
		psel         = 1'b0;
		penable      = 1'b0;
		pwrite       = 1'b0;
		paddr        = '0;
		pwdata       = '0;
		in_valid     = 1'b0;
		cmd          = CMD_FLUSH;
		word_in      = '0;
		batch_count  = '0;
		trigger_flag = 1'b0;
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed: indicate rules, empty cases, word extremes, spare codes, flush
		push_cmd(CMD_IND, 32'h0, 6'd0, 1'b0);
		push_cmd(CMD_IND, 32'h0, 6'd0, 1'b0);
		push_cmd(CMD_IND, 32'h0, 6'd0, 1'b1);
		push_cmd(CMD_DEQ, 32'h0, 6'd0, 1'b0);
		push_cmd(CMD_BATCH, 32'h0, 6'd5, 1'b0);
		push_cmd(CMD_ENQ, 32'h0000_0000, 6'd0, 1'b0);
		push_cmd(CMD_ENQ, 32'hffff_ffff, 6'd63, 1'b1);
		push_cmd(CMD_BATCH, 32'h0, 6'd0, 1'b0);
		push_cmd(CMD_BATCH, 32'h0, 6'd63, 1'b0);
		for (int c = FIRST_SPARE_CMD; c <= LAST_SPARE_CMD; c++)
			push_cmd(3'(c), $urandom, 6'($urandom_range(63)), 1'b1);
		push_cmd(CMD_ENQ, 32'h1234_5678, 6'd0, 1'b0);
		push_cmd(CMD_FLUSH, 32'h0, 6'd0, 1'b0);
		push_cmd(CMD_DEQ, 32'h0, 6'd0, 1'b0);

		// capacity one, every mode on: pops on an empty queue are skipped
		retune(6'd1, 1'b1, 1'b1, 1'b1);
		push_cmd(CMD_DEQ, 32'h0, 6'd0, 1'b0);
		push_cmd(CMD_ENQ, 32'ha5a5_a5a5, 6'd0, 1'b0);
		push_cmd(CMD_ENQ, 32'h5a5a_5a5a, 6'd0, 1'b0);

		// pending first-pop and remembered dequeue served in turn, then a drop when full
		retune(6'd2, 1'b1, 1'b1, 1'b0);
		push_cmd(CMD_ENQ, 32'h0000_0001, 6'd0, 1'b0);
		push_cmd(CMD_ENQ, 32'h0000_0002, 6'd0, 1'b0);
		push_cmd(CMD_ENQ, 32'h0000_0003, 6'd0, 1'b0);
		push_cmd(CMD_ENQ, 32'h0000_0004, 6'd0, 1'b0);
		push_cmd(CMD_ENQ, 32'h0000_0005, 6'd0, 1'b0);
		push_cmd(CMD_BATCH, 32'h0, 6'd1, 1'b0);
		push_cmd(CMD_BATCH, 32'h0, 6'd63, 1'b0);

		// random phases over several register settings
		retune(6'd32, 1'b0, 1'b0, 1'b0);
		idle_pct  = 0;
		stall_pct = 0;
		random_traffic(25, 70);

		retune(6'd4, 1'b1, 1'b1, 1'b1);
		idle_pct  = 48;
		stall_pct = 0;
		random_traffic(20, 55);

		retune(6'd0, 1'($urandom_range(1)), 1'($urandom_range(1)), 1'($urandom_range(1)));
		idle_pct  = 0;
		stall_pct = 48;
		random_traffic(15, 50);

		// capacity above the store size, enqueue heavy so the queue fills up
		retune(6'd63, 1'b0, 1'b1, 1'b1);
		idle_pct  = 20;
		stall_pct = 20;
		random_traffic(40, 80);

		// lower capacity while the queue may still hold more words
		retune(6'($urandom_range(1, 8)), 1'($urandom_range(1)), 1'($urandom_range(1)),
			1'($urandom_range(1)));
		idle_pct  = 0;
		stall_pct = 0;
		random_traffic(25, 50);

		retune(6'd2, 1'b1, 1'b0, 1'b1);
		idle_pct  = 0;
		stall_pct = 48;
		random_traffic(20, 60);

		settle();
		if (fail_count == 0)
			$display("[ OK ] regression clean");
		else
			$display("[FAIL] regression broken");
		$finish;
	end

endmodule

### files.f
rtl/core/cfd_pkg.sv
rtl/core/cfd_ram.sv
rtl/core/cfd_regs.sv
rtl/core/cfd_ctrl.sv
rtl/core/command_fifo_auto_dequeue.sv
verif/cfd_result_checker.sv
verif/tb_top.sv
